// File: src/ffba_pkg.sv
// ffba_pkg: shared types and constants of the first-fit block allocator
// no dependencies; used by the interfaces, the controller, the datapath and the top level

package ffba_pkg;

  // fixed field widths of the channels
  localparam int unsigned ActionW   = 1;
  localparam int unsigned IndexW    = 4;
  localparam int unsigned ReqSizeW  = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned OutSizeW  = 16;

  // action codes
  localparam logic [ActionW-1:0] ACT_LOAD  = 1'b0;
  localparam logic [ActionW-1:0] ACT_ALLOC = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ffba_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;   // write a loaded size into both tables
    logic start;     // latch request and clear scan pointer
    logic scan;      // scan step in progress
    logic load_out;  // move the staged result into the output register
  } ffba_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;       // current block fits the request
    logic miss;      // scan ran out of blocks
  } ffba_sts_t;

endpackage

// File: src/ffba_req_if.sv
// ffba_req_if: request channel (load or allocate items) with valid/ready
// depends on ffba_pkg for field widths

interface ffba_req_if;
  logic                               valid;
  logic                               ready;
  logic [ffba_pkg::ActionW-1:0]       action;
  logic [ffba_pkg::IndexW-1:0]        block_index;
  logic [ffba_pkg::ReqSizeW-1:0]      request_size;

  modport source (output valid, output action, output block_index, output request_size,
                  input ready);
  modport sink   (input valid, input action, input block_index, input request_size,
                  output ready);
endinterface

// File: src/ffba_rsp_if.sv
// ffba_rsp_if: result channel of allocate items with valid/ready
// depends on ffba_pkg for field widths

interface ffba_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               granted;
  logic [ffba_pkg::IndexW-1:0]        block_number;
  logic [ffba_pkg::OutSizeW-1:0]      original_size;
  logic [ffba_pkg::OutSizeW-1:0]      hole_size;

  modport source (output valid, output granted, output block_number, output original_size,
                  output hole_size, input ready);
  modport sink   (input valid, input granted, input block_number, input original_size,
                  input hole_size, output ready);
endinterface

// File: src/ffba_cfg_if.sv
// ffba_cfg_if: configuration write channel carrying the block count
// depends on ffba_pkg for the register width

interface ffba_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ffba_pkg::CountW-1:0]        data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ffba_ctrl.sv
// ffba_ctrl: controller state machine of the allocator
// depends on ffba_pkg for state, command and status types

module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_action_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ffba_pkg::ffba_sts_t sts_i,
  output ffba_pkg::ffba_cmd_t cmd_o
);
  import ffba_pkg::*;

  ffba_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_xfer;
  logic        out_free;

  assign in_xfer  = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_action_i == ACT_ALLOC)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit || sts_i.miss) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_wr = in_xfer && (in_action_i == ACT_LOAD);
        cmd_o.start   = in_xfer && (in_action_i == ACT_ALLOC);
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // output valid flag: set on result load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out)             out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/ffba_dp.sv
// ffba_dp: datapath of the allocator: size tables, scan pointer, compare, result registers
// depends on ffba_pkg for command, status and width constants

module ffba_dp #(
  parameter int unsigned BLOCKS    = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ffba_pkg::ffba_cmd_t              cmd_i,
  output ffba_pkg::ffba_sts_t              sts_o,
  input  logic [ffba_pkg::IndexW-1:0]      block_index_i,
  input  logic [ffba_pkg::ReqSizeW-1:0]    request_size_i,
  input  logic                             cfg_we_i,
  input  logic [ffba_pkg::CountW-1:0]      cfg_data_i,
  output logic                             granted_o,
  output logic [ffba_pkg::IndexW-1:0]      block_number_o,
  output logic [ffba_pkg::OutSizeW-1:0]    original_size_o,
  output logic [ffba_pkg::OutSizeW-1:0]    hole_size_o
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int unsigned CntW = ($clog2(BLOCKS + 1) > CountW) ? $clog2(BLOCKS + 1) : CountW;

  // size tables
  logic [SIZE_BITS-1:0] rem_mem  [BLOCKS];
  logic [SIZE_BITS-1:0] orig_mem [BLOCKS];

  logic [CountW-1:0]    block_count_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [CntW-1:0]      ptr_q;
  logic                 dv_q;
  logic [IdxW-1:0]      cidx_q;
  logic [SIZE_BITS-1:0] rd_rem_q, rd_orig_q;

  logic                 res_granted_q;
  logic [IndexW-1:0]    res_number_q;
  logic [OutSizeW-1:0]  res_orig_q, res_hole_q;

  logic                 out_granted_q;
  logic [IndexW-1:0]    out_number_q;
  logic [OutSizeW-1:0]  out_orig_q, out_hole_q;

  logic [CntW-1:0]      limit;
  logic                 more;
  logic                 hit, miss, issue;
  logic [SIZE_BITS-1:0] diff;
  logic [SIZE_BITS-1:0] in_size;
  logic [IdxW-1:0]      load_addr;
  logic                 load_ok;
  logic                 mem_we;
  logic [IdxW-1:0]      wr_addr;
  logic [SIZE_BITS-1:0] wr_rem;
  logic [IdxW-1:0]      rd_addr;

  logic [SIZE_BITS+ReqSizeW-1:0] size_ext;
  logic [IdxW+IndexW-1:0]        idx_ext;
  logic [IdxW+IndexW-1:0]        num_ext;
  logic [SIZE_BITS+OutSizeW-1:0] orig_ext, hole_ext;

  // request size cut or zero-extended to the table width
  assign size_ext  = {{SIZE_BITS{1'b0}}, request_size_i};
  assign in_size   = size_ext[SIZE_BITS-1:0];
  assign idx_ext   = {{IdxW{1'b0}}, block_index_i};
  assign load_addr = idx_ext[IdxW-1:0];
  assign load_ok   = CntW'(block_index_i) < CntW'(BLOCKS);

  // scan limit saturates at the table depth
  assign limit = (CntW'(block_count_q) > CntW'(BLOCKS)) ? CntW'(BLOCKS)
                                                         : CntW'(block_count_q);
  assign more  = ptr_q < limit;

  // compare of the block read last cycle
  assign diff  = rd_rem_q - size_q;
  assign hit   = cmd_i.scan && dv_q && (rd_rem_q >= size_q);
  assign miss  = cmd_i.scan && !dv_q && !more;
  assign issue = cmd_i.scan && !hit && more;

  assign sts_o.hit  = hit;
  assign sts_o.miss = miss;

  // table write port: loads write both, a grant updates the free size
  assign mem_we  = (cmd_i.load_wr && load_ok) || hit;
  assign wr_addr = cmd_i.load_wr ? load_addr : cidx_q;
  assign wr_rem  = cmd_i.load_wr ? in_size : diff;
  assign rd_addr = ptr_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rem_mem[wr_addr] <= wr_rem;
    end
    if (issue) begin
      rd_rem_q <= rem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_ok) begin
      orig_mem[wr_addr] <= in_size;
    end
    if (issue) begin
      rd_orig_q <= orig_mem[rd_addr];
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
    end else if (cfg_we_i) begin
      block_count_q <= cfg_data_i;
    end
  end

  // scan pointer and read-data valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      dv_q  <= 1'b0;
    end else begin
      dv_q <= issue;
      if (cmd_i.start) begin
        ptr_q <= '0;
      end else if (issue) begin
        ptr_q <= ptr_q + CntW'(1);
      end
    end
  end

  // request size and index of the block in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q <= in_size;
    end
    if (issue) begin
      cidx_q <= rd_addr;
    end
  end

  // result fields in output widths
  assign num_ext  = {{IndexW{1'b0}}, cidx_q};
  assign orig_ext = {{OutSizeW{1'b0}}, rd_orig_q};
  assign hole_ext = {{OutSizeW{1'b0}}, diff};

  // staged result
  always_ff @(posedge clk_i) begin
    if (hit) begin
      res_granted_q <= 1'b1;
      res_number_q  <= num_ext[IndexW-1:0];
      res_orig_q    <= orig_ext[OutSizeW-1:0];
      res_hole_q    <= hole_ext[OutSizeW-1:0];
    end else if (miss) begin
      res_granted_q <= 1'b0;
      res_number_q  <= '0;
      res_orig_q    <= '0;
      res_hole_q    <= '0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_granted_q <= res_granted_q;
      out_number_q  <= res_number_q;
      out_orig_q    <= res_orig_q;
      out_hole_q    <= res_hole_q;
    end
  end

  assign granted_o       = out_granted_q;
  assign block_number_o  = out_number_q;
  assign original_size_o = out_orig_q;
  assign hole_size_o     = out_hole_q;

endmodule

// File: src/first_fit_block_allocator.sv
// first_fit_block_allocator: top level joining controller and datapath
// depends on ffba_pkg, ffba_req_if, ffba_rsp_if, ffba_cfg_if, ffba_ctrl and ffba_dp
//
// usage:
//   cfg_i   writes the block count (blocks scanned from block zero, capped at BLOCKS);
//           always ready, write only while the block is idle
//   req_i   takes load items (action 0: block size into block_index) and allocate
//           items (action 1: request_size); a load completes in the transfer cycle
//           and gives no result
//   rsp_o   gives one result per allocate: granted, block number, loaded size and
//           hole left; all zero when no block fits
// scan:
//   an allocate reads one table entry per cycle through the registered read port
//   and compares it in the next cycle; a hit at block n, or a miss once limit blocks
//   are read (at once when limit is 0), is staged and then moves to the output register;
//   the next request is taken after that move, so items are handled one at a time
// reset:
//   block count clears to zero and all control returns to idle; the size tables
//   are not cleared and must be loaded before they are scanned
// stall:
//   a result waits in the output register while a new request is taken; a second
//   allocate holds before the output register until the first result is transferred

module first_fit_block_allocator #(
  parameter int unsigned BLOCKS    = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffba_req_if.sink   req_i,
  ffba_rsp_if.source rsp_o,
  ffba_cfg_if.sink   cfg_i
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  assign cfg_i.ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_action_i (req_i.action),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffba_dp #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .block_index_i   (req_i.block_index),
    .request_size_i  (req_i.request_size),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .granted_o       (rsp_o.granted),
    .block_number_o  (rsp_o.block_number),
    .original_size_o (rsp_o.original_size),
    .hole_size_o     (rsp_o.hole_size)
  );

endmodule

// File: verif/ffba_alloc_checker.sv
`timescale 1ns / 100ps
// ffba_alloc_checker: watches the request, result and block-count channels of the allocator,
// keeps its own first-fit size tables and compares every result transfer field by field
// depends on ffba_pkg, ffba_req_if, ffba_rsp_if and ffba_cfg_if

module ffba_alloc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffba_req_if         req_i,
  ffba_rsp_if         rsp_i,
  ffba_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned grants_o,
  output int unsigned refusals_o
);
  import ffba_pkg::*;

  localparam int unsigned Blocks = 16;

  typedef struct packed {
    logic                granted;
    logic [IndexW-1:0]   block_number;
    logic [OutSizeW-1:0] original_size;
    logic [OutSizeW-1:0] hole_size;
  } alloc_result_t;

  // shadow of the size tables and the block count
  logic [ReqSizeW-1:0] free_size   [Blocks];
  logic [ReqSizeW-1:0] loaded_size [Blocks];
  logic [CountW-1:0]   blocks_in_use;

  alloc_result_t results_due [$];
  alloc_result_t due;
  int unsigned   mismatches;
  int unsigned   grants;
  int unsigned   refusals;

  // first block whose free size covers the request, carved down by the request
  function automatic alloc_result_t first_fit(input logic [ReqSizeW-1:0] want);
    alloc_result_t res;
    int unsigned   limit;
    bit            found;
    res   = '0;
    found = 1'b0;
    limit = (blocks_in_use < Blocks) ? blocks_in_use : Blocks;
    for (int unsigned j = 0; j < limit; j++) begin
      if (!found && free_size[j] >= want) begin
        found             = 1'b1;
        free_size[j]      = free_size[j] - want;
        res.granted       = 1'b1;
        res.block_number  = j[IndexW-1:0];
        res.original_size = loaded_size[j];
        res.hole_size     = free_size[j];
      end
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // one pass per clock: retire results, then take config and request transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned j = 0; j < Blocks; j++) begin
        free_size[j]   = '0;
        loaded_size[j] = '0;
      end
      blocks_in_use = '0;
      results_due.delete();
      mismatches    = 0;
      grants        = 0;
      refusals      = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      grants_o     <= 0;
      refusals_o   <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (results_due.size() == 0) begin
          $error("result transfer with no allocate waiting: granted %0d block %0d",
                 rsp_i.granted, rsp_i.block_number);
          mismatches++;
        end else begin
          due = results_due.pop_front();
          check_field("granted", 32'(due.granted), 32'(rsp_i.granted));
          check_field("block_number", 32'(due.block_number), 32'(rsp_i.block_number));
          check_field("original_size", 32'(due.original_size), 32'(rsp_i.original_size));
          check_field("hole_size", 32'(due.hole_size), 32'(rsp_i.hole_size));
        end
      end

      if (cfg_i.valid && cfg_i.ready) begin
        blocks_in_use = cfg_i.data;
      end

      if (req_i.valid && req_i.ready) begin
        if (req_i.action == ACT_LOAD) begin
          free_size[req_i.block_index]   = req_i.request_size;
          loaded_size[req_i.block_index] = req_i.request_size;
        end else begin
          due = first_fit(req_i.request_size);
          results_due.push_back(due);
          if (due.granted) begin
            grants++;
          end else begin
            refusals++;
          end
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= results_due.size();
      grants_o     <= grants;
      refusals_o   <= refusals;
    end
  end

endmodule

// File: verif/first_fit_block_allocator_test.sv
`timescale 1ns / 100ps
// first_fit_block_allocator_test: drives load and allocate items and block-count writes
// into the allocator, stalls the result side, and reports the checker's verdict
// depends on ffba_pkg, the three channel interfaces, first_fit_block_allocator and ffba_alloc_checker

module first_fit_block_allocator_test;
  import ffba_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned Phases        = 10;
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned LongHoldCycles = 150;

  logic clk_i;
  logic rst_ni;

  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();
  ffba_cfg_if cfg_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned grants;
  int unsigned refusals;

  // stimulus controls, changed by the main process (calm and hold_arm with nonblocking writes)
  int unsigned gap_pct;
  bit          calm;
  bit          hold_arm;
  int unsigned loads_sent;
  int unsigned allocs_sent;
  int unsigned count_writes;

  first_fit_block_allocator #(
    .BLOCKS   (16),
    .SIZE_BITS(16)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  ffba_alloc_checker u_alloc_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .cfg_i       (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .grants_o    (grants),
    .refusals_o  (refusals)
  );

  // clock
  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // run limit, far above the slowest legal run
  initial begin
    #(2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: short random stalls, one long hold-off, none once calm
  initial begin : rsp_drain
    int unsigned pause;
    int unsigned long_hold;
    bit          held;
    pause     = 0;
    long_hold = 0;
    held      = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_arm && !held) begin
        held      = 1'b1;
        long_hold = LongHoldCycles;
      end
      if (long_hold != 0) begin
        long_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (pause != 0) begin
        pause--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        pause = $urandom_range(0, 2);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // offer one item, with an optional gap first, and wait for its transfer
  task automatic offer_item(input logic [ActionW-1:0] act, input logic [IndexW-1:0] idx,
                            input logic [ReqSizeW-1:0] sz);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.block_index  <= idx;
    req_ch.request_size <= sz;
    do @(posedge clk_i); while (!req_ch.ready);
    if (act == ACT_LOAD) begin
      loads_sent++;
    end else begin
      allocs_sent++;
    end
  endtask

  // drain all results, let the block settle, then write the block count
  task automatic set_block_count(input logic [CountW-1:0] n);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= n;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    count_writes++;
  endtask

  initial begin : stimulus
    logic [ActionW-1:0]  act;
    logic [IndexW-1:0]   idx;
    logic [ReqSizeW-1:0] sz;
    logic [CountW-1:0]   cnt;

    loads_sent   = 0;
    allocs_sent  = 0;
    count_writes = 0;
    gap_pct      = 0;
    calm         <= 1'b0;
    hold_arm     <= 1'b0;
    rst_ni              <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_LOAD;
    req_ch.block_index  <= '0;
    req_ch.request_size <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: load every block so no scan ever touches an unwritten entry
    offer_item(ACT_LOAD, 4'd0, 16'd100);
    offer_item(ACT_LOAD, 4'd1, 16'h0000);
    offer_item(ACT_LOAD, 4'd2, 16'hFFFF);
    for (int unsigned b = 3; b < 15; b++) begin
      offer_item(ACT_LOAD, b[IndexW-1:0], 16'($urandom()) & 16'h7FFF);
    end
    offer_item(ACT_LOAD, 4'd15, 16'hFFFF);

    // block count still zero from reset: nothing can be granted
    offer_item(ACT_ALLOC, 4'd7, 16'd5);

    set_block_count(5'd16);
    // zero request is granted block zero and leaves its size whole, then an exact fit leaves no hole
    offer_item(ACT_ALLOC, 4'd0, 16'd0);
    offer_item(ACT_ALLOC, 4'd15, 16'd100);
    // skips the emptied and the zero-size block
    offer_item(ACT_ALLOC, 4'd3, 16'd1);
    // largest request fits only the last block, then nowhere
    offer_item(ACT_ALLOC, 4'd9, 16'hFFFF);
    offer_item(ACT_ALLOC, 4'd9, 16'hFFFF);

    // single block in use, already empty
    set_block_count(5'd1);
    offer_item(ACT_ALLOC, 4'd2, 16'd1);

    set_block_count(5'd3);
    offer_item(ACT_ALLOC, 4'd12, 16'hFFFE);

    // random phases over several block counts
    for (int unsigned p = 0; p < Phases; p++) begin
      if (p == 0 || p == Phases - 1) begin
        cnt = 5'd16;
      end else if (p == 1) begin
        cnt = 5'd0;
      end else if (p == 2) begin
        cnt = 5'd1;
      end else begin
        cnt = 5'($urandom_range(1, 16));
      end
      set_block_count(cnt);

      if (p == 3) begin
        hold_arm <= 1'b1;
      end
      if (p >= Phases - 2) begin
        calm    <= 1'b1;
        gap_pct  = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 35;
        endcase
      end

      for (int unsigned k = 0; k < PhaseItems; k++) begin
        act = ($urandom_range(0, 9) < 3) ? ACT_LOAD : ACT_ALLOC;
        idx = IndexW'($urandom_range(0, 15));
        if (act == ACT_LOAD) begin
          case ($urandom_range(0, 3))
            0:       sz = ReqSizeW'($urandom_range(0, 63));
            1:       sz = ReqSizeW'($urandom());
            2:       sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: sz = ReqSizeW'($urandom_range(256, 4095));
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0:       sz = ReqSizeW'($urandom_range(0, 63));
            1:       sz = ReqSizeW'($urandom_range(64, 1023));
            2:       sz = ReqSizeW'($urandom());
            default: sz = ReqSizeW'($urandom_range(0, 1));
          endcase
        end
        offer_item(act, idx, sz);
      end
    end

    // drain and let the last scan finish
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("summary: %0d loads and %0d allocates (%0d granted, %0d refused)",
             loads_sent, allocs_sent, grants, refusals);
    $display("summary: %0d block-count writes, long result hold-off included", count_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
